FILE: rtl/asbf_pkg.sv
// ----------------------------------------------------------------------------
// asbf_pkg
// Shared widths, command codes and control/status types for the analog
// stick boost filter.
// ----------------------------------------------------------------------------
`default_nettype none

package asbf_pkg;

	// field widths
	localparam int AXIS_W     = 16;
	localparam int MAG_W      = 16;
	localparam int CHG_W      = 17;
	localparam int SUM_W      = 18;
	localparam int BOOST_W    = 20;
	localparam int ACC_W      = 24;
	localparam int DECAY_W    = 15;
	localparam int GAIN_W     = 17;
	localparam int BOUT_W     = 19;
	localparam int SOUT_W     = 16;
	localparam int FRAC_W     = 14;
	localparam int ONE_Q14    = 1 << FRAC_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
	localparam logic [DECAY_W-1:0]   DECAY_RST = 15'd328;
	localparam logic [GAIN_W-1:0]    GAIN_RST  = 17'd32768;

	// iterative units
	localparam int RAD_W = 32;
	localparam int DVD_W = 36;
	localparam int DVS_W = 16;

	// datapath command codes
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
	localparam logic [OP_W-1:0] OP_MXX    = 5'd2;
	localparam logic [OP_W-1:0] OP_MYY    = 5'd3;
	localparam logic [OP_W-1:0] OP_SQS    = 5'd4;
	localparam logic [OP_W-1:0] OP_MAG    = 5'd5;
	localparam logic [OP_W-1:0] OP_MBM    = 5'd6;
	localparam logic [OP_W-1:0] OP_MRISE  = 5'd7;
	localparam logic [OP_W-1:0] OP_BCOPY  = 5'd8;
	localparam logic [OP_W-1:0] OP_FDIV   = 5'd9;
	localparam logic [OP_W-1:0] OP_FGET   = 5'd10;
	localparam logic [OP_W-1:0] OP_RADD   = 5'd11;
	localparam logic [OP_W-1:0] OP_DEC    = 5'd12;
	localparam logic [OP_W-1:0] OP_CLMP   = 5'd13;
	localparam logic [OP_W-1:0] OP_THR    = 5'd14;
	localparam logic [OP_W-1:0] OP_CAP    = 5'd15;
	localparam logic [OP_W-1:0] OP_ACC    = 5'd16;
	localparam logic [OP_W-1:0] OP_BXDIV  = 5'd17;
	localparam logic [OP_W-1:0] OP_BXGET  = 5'd18;
	localparam logic [OP_W-1:0] OP_BYDIV  = 5'd19;
	localparam logic [OP_W-1:0] OP_BYGET  = 5'd20;
	localparam logic [OP_W-1:0] OP_MSX    = 5'd21;
	localparam logic [OP_W-1:0] OP_SXGET  = 5'd22;
	localparam logic [OP_W-1:0] OP_SYGET  = 5'd23;
	localparam logic [OP_W-1:0] OP_COMMIT = 5'd24;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic sq_busy;
		logic dv_busy;
		logic s_neg;
		logic s_pos;
		logic pm_nz;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/asbf_isqrt.sv
// ----------------------------------------------------------------------------
// asbf_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asbf_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [asbf_pkg::RAD_W-1:0]   radicand,
	output logic                         busy,
	output logic [asbf_pkg::MAG_W-1:0]   root
);
	import asbf_pkg::*;

	localparam int ITER  = RAD_W / 2;
	localparam int CNT_W = $clog2(ITER);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [MAG_W:0]   rem_q;
	logic [MAG_W-1:0] root_q;
	logic [MAG_W+2:0] rem_sh;
	logic [MAG_W+2:0] trial;
	logic             ge;

	// next two radicand bits against the trial value
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ITER - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (MAG_W+1)'(rem_sh - trial) : rem_sh[MAG_W:0];
			root_q <= {root_q[MAG_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

FILE: rtl/asbf_div.sv
// ----------------------------------------------------------------------------
// asbf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module asbf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [asbf_pkg::DVD_W-1:0]  dividend,
	input  logic [asbf_pkg::DVS_W-1:0]  divisor,
	output logic                        busy,
	output logic [asbf_pkg::DVD_W-1:0]  quotient
);
	import asbf_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge;

	// shift in the next dividend bit and try the subtract
	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/asbf_dp.sv
// ----------------------------------------------------------------------------
// asbf_dp
// Datapath: shared multiplier, square root and divider, filter state,
// configuration registers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module asbf_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  asbf_pkg::cmd_t                     cmd,
	output asbf_pkg::stat_t                    stat,
	input  logic signed [asbf_pkg::AXIS_W-1:0] axis_x,
	input  logic signed [asbf_pkg::AXIS_W-1:0] axis_y,
	input  logic                               cfg_we,
	input  logic [asbf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asbf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic signed [asbf_pkg::BOUT_W-1:0] boosted_x,
	output logic signed [asbf_pkg::BOUT_W-1:0] boosted_y,
	output logic signed [asbf_pkg::SOUT_W-1:0] scaled_x,
	output logic signed [asbf_pkg::SOUT_W-1:0] scaled_y
);
	import asbf_pkg::*;

	localparam int AX_W   = AXIS_W + 1;
	localparam int MA_W   = 25;
	localparam int MB_W   = 22;
	localparam int MP_W   = MA_W + MB_W;
	localparam int WB_W   = 38;
	localparam int ACCD_W = ACC_W + DECAY_W;
	localparam int ACCS_W = ACC_W + 2;
	localparam int UP_LO  = FRAC_W;
	localparam int UP_HI  = MAG_W + GAIN_W - 1;
	localparam int BO_LIM = 1 << (BOUT_W - 1);

	localparam logic signed [WB_W-1:0] ONE_W   = WB_W'(ONE_Q14);
	localparam logic signed [WB_W-1:0] BMAX_W  = WB_W'((1 << BOOST_W) - 1);
	localparam logic signed [MP_W-1:0] HALF_RND = MP_W'(2 * ONE_Q14 - 1);
	localparam logic signed [MP_W-1:0] S_MAX   = MP_W'((1 << (SOUT_W - 1)) - 1);
	localparam logic signed [MP_W-1:0] S_MIN   = -S_MAX - MP_W'(1);

	// working registers
	logic signed [AXIS_W-1:0] x_q, y_q;
	logic [RAD_W-1:0]         sumsq_q;
	logic [MAG_W-1:0]         m_q;
	logic signed [CHG_W-1:0]  d_q;
	logic signed [SUM_W-1:0]  s_q;
	logic signed [WB_W-1:0]   b_q;
	logic [ACCD_W-1:0]        accd_q;
	logic [ACC_W-1:0]         accn_q;
	logic signed [MP_W-1:0]   prod_q;
	logic signed [BOUT_W-1:0] bxn_q, byn_q, bx_q, by_q;
	logic signed [SOUT_W-1:0] sxn_q, syn_q, sx_q, sy_q;

	// filter state and configuration
	logic [MAG_W-1:0]         pm_q;
	logic signed [CHG_W-1:0]  pc_q;
	logic [BOOST_W-1:0]       boost_q;
	logic [ACC_W-1:0]         acc_q;
	logic [DECAY_W-1:0]       decay_q;
	logic [GAIN_W-1:0]        gain_q;

	// combinational helpers
	logic [AX_W-1:0]          ax, ay;
	logic [MAG_W:0]           mplus;
	logic [GAIN_W:0]          gplus;
	logic signed [GAIN_W:0]   ag;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [MP_W-1:0]   mul_p;
	logic [RAD_W-1:0]         radicand;
	logic                     sq_start, sq_busy;
	logic [MAG_W-1:0]         root;
	logic                     dv_start, dv_busy;
	logic [DVD_W-1:0]         dv_q;
	logic [DVS_W-1:0]         divisor;
	logic signed [CHG_W-1:0]  d_n;
	logic signed [SUM_W-1:0]  s_n;
	logic signed [WB_W-1:0]   upper_w, m_w, b_clmp, b_sat, b_cap;
	logic                     cap_hit;
	logic signed [ACCS_W-1:0] acc_sum;
	logic [ACC_W-1:0]         accn;

	function automatic logic [BOUT_W-1:0] sat_div(input logic [DVD_W-1:0] q,
			input logic neg);
		logic [DVD_W-1:0]  lim;
		logic [BOUT_W-1:0] mag;
		lim = neg ? DVD_W'(BO_LIM) : DVD_W'(BO_LIM - 1);
		mag = (q > lim) ? lim[BOUT_W-1:0] : q[BOUT_W-1:0];
		return neg ? BOUT_W'(-mag) : mag;
	endfunction

	function automatic logic [SOUT_W-1:0] sat_half(input logic signed [MP_W-1:0] p);
		logic signed [MP_W-1:0] adj;
		logic signed [MP_W-1:0] t;
		adj = p + (p[MP_W-1] ? HALF_RND : MP_W'(0));
		t   = adj >>> (FRAC_W + 1);
		if (t > S_MAX) begin
			t = S_MAX;
		end else if (t < S_MIN) begin
			t = S_MIN;
		end
		return t[SOUT_W-1:0];
	endfunction

	// magnitudes of the axes and offset operands
	assign ax    = x_q[AXIS_W-1] ? AX_W'(-$signed({x_q[AXIS_W-1], x_q})) : {1'b0, x_q};
	assign ay    = y_q[AXIS_W-1] ? AX_W'(-$signed({y_q[AXIS_W-1], y_q})) : {1'b0, y_q};
	assign mplus = {1'b0, m_q} + (MAG_W+1)'(ONE_Q14);
	assign gplus = {1'b0, gain_q} + (GAIN_W+1)'(ONE_Q14);
	assign ag    = $signed({1'b0, gain_q}) - $signed((GAIN_W+1)'(ONE_Q14));

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MXX: begin
				mul_a = MA_W'(x_q);
				mul_b = MB_W'(x_q);
			end
			OP_MYY: begin
				mul_a = MA_W'(y_q);
				mul_b = MB_W'(y_q);
			end
			OP_MBM: begin
				mul_a = MA_W'(boost_q);
				mul_b = MB_W'(m_q);
			end
			OP_MRISE: begin
				mul_a = MA_W'(gplus);
				mul_b = MB_W'(s_q);
			end
			OP_DEC: begin
				mul_a = MA_W'(m_q);
				mul_b = MB_W'(gain_q);
			end
			OP_CLMP: begin
				mul_a = MA_W'(acc_q);
				mul_b = MB_W'(decay_q);
			end
			OP_THR: begin
				mul_a = MA_W'(ag);
				mul_b = MB_W'(ag);
			end
			OP_ACC: begin
				mul_a = MA_W'(ax);
				mul_b = MB_W'(b_q[BOOST_W-1:0]);
			end
			OP_BXGET: begin
				mul_a = MA_W'(ay);
				mul_b = MB_W'(b_q[BOOST_W-1:0]);
			end
			OP_MSX: begin
				mul_a = MA_W'(x_q);
				mul_b = MB_W'(mplus);
			end
			OP_SXGET: begin
				mul_a = MA_W'(y_q);
				mul_b = MB_W'(mplus);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

	// square root and divider hookup
	assign radicand = sumsq_q + prod_q[RAD_W-1:0];
	assign sq_start = cmd.op == OP_SQS;
	assign dv_start = (cmd.op == OP_FDIV) || (cmd.op == OP_BXDIV) || (cmd.op == OP_BYDIV);
	assign divisor  = (cmd.op == OP_FDIV) ? pm_q : m_q;

	asbf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.busy     (sq_busy),
		.root     (root)
	);

	asbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (prod_q[DVD_W-1:0]),
		.divisor  (divisor),
		.busy     (dv_busy),
		.quotient (dv_q)
	);

	// change in magnitude and its two-sample sum
	assign d_n = $signed({1'b0, root}) - $signed({1'b0, pm_q});
	assign s_n = SUM_W'(d_n) + SUM_W'(pc_q);

	// clamp between magnitude and magnitude times gain
	assign upper_w = WB_W'(prod_q[UP_HI:UP_LO]);
	assign m_w     = WB_W'(m_q);
	assign b_clmp  = (b_q > upper_w) ? upper_w : ((b_q < m_w) ? m_w : b_q);

	// overshoot cap: acc > floor(a*a/decay) is acc*decay > a*a
	assign cap_hit = (b_q > ONE_W) && (decay_q != '0) && (accd_q > prod_q[ACCD_W-1:0]);
	assign b_sat   = b_q[WB_W-1] ? '0 : ((b_q > BMAX_W) ? BMAX_W : b_q);
	assign b_cap   = cap_hit ? ONE_W : b_sat;

	// overshoot accumulator update
	assign acc_sum = ACCS_W'(acc_q) + ACCS_W'(b_q[BOOST_W-1:0]) - ACCS_W'(ONE_Q14);
	assign accn    = acc_sum[ACCS_W-1] ? '0 :
		((acc_sum[ACCS_W-2:ACC_W] != '0) ? '1 : acc_sum[ACC_W-1:0]);

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (cmd.op)
			OP_LOAD: begin
				x_q <= axis_x;
				y_q <= axis_y;
			end
			OP_MYY:   sumsq_q <= prod_q[RAD_W-1:0];
			OP_MAG: begin
				m_q <= root;
				d_q <= d_n;
				s_q <= s_n;
			end
			OP_BCOPY: b_q <= WB_W'(boost_q);
			OP_FGET:  b_q <= WB_W'(dv_q);
			OP_RADD:  b_q <= WB_W'(boost_q) + WB_W'(prod_q >>> (FRAC_W + 1));
			OP_DEC:   b_q <= b_q - WB_W'(decay_q);
			OP_CLMP:  b_q <= b_clmp;
			OP_THR:   accd_q <= prod_q[ACCD_W-1:0];
			OP_CAP:   b_q <= b_cap;
			OP_ACC:   accn_q <= accn;
			OP_BXGET: bxn_q <= (m_q == '0) ? '0 : sat_div(dv_q, x_q[AXIS_W-1]);
			OP_BYGET: byn_q <= (m_q == '0) ? '0 : sat_div(dv_q, y_q[AXIS_W-1]);
			OP_SXGET: sxn_q <= sat_half(prod_q);
			OP_SYGET: syn_q <= sat_half(prod_q);
			OP_COMMIT: begin
				bx_q <= bxn_q;
				by_q <= byn_q;
				sx_q <= sxn_q;
				sy_q <= syn_q;
			end
			default: begin
			end
		endcase
	end

	// filter state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q    <= '0;
			pc_q    <= '0;
			boost_q <= '0;
			acc_q   <= '0;
			decay_q <= DECAY_RST;
			gain_q  <= GAIN_RST;
		end else begin
			if (cmd.op == OP_COMMIT) begin
				pm_q    <= m_q;
				pc_q    <= d_q;
				boost_q <= b_q[BOOST_W-1:0];
				acc_q   <= accn_q;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DECAY: decay_q <= cfg_data[DECAY_W-1:0];
					REG_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// status to the controller
	assign stat.sq_busy = sq_busy;
	assign stat.dv_busy = dv_busy;
	assign stat.s_neg   = s_q[SUM_W-1];
	assign stat.s_pos   = !s_q[SUM_W-1] && (s_q != '0);
	assign stat.pm_nz   = pm_q != '0;

	assign boosted_x = bx_q;
	assign boosted_y = by_q;
	assign scaled_x  = sx_q;
	assign scaled_y  = sy_q;

endmodule

`default_nettype wire

FILE: rtl/asbf_ctrl.sv
// ----------------------------------------------------------------------------
// asbf_ctrl
// Sequencer: steps the datapath through one sample and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module asbf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  asbf_pkg::stat_t stat,
	output asbf_pkg::cmd_t  cmd
);
	import asbf_pkg::*;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
	localparam logic [ST_W-1:0] ST_MXX  = 5'd1;
	localparam logic [ST_W-1:0] ST_MYY  = 5'd2;
	localparam logic [ST_W-1:0] ST_SQS  = 5'd3;
	localparam logic [ST_W-1:0] ST_SQW  = 5'd4;
	localparam logic [ST_W-1:0] ST_BR   = 5'd5;
	localparam logic [ST_W-1:0] ST_FDS  = 5'd6;
	localparam logic [ST_W-1:0] ST_FDW  = 5'd7;
	localparam logic [ST_W-1:0] ST_RADD = 5'd8;
	localparam logic [ST_W-1:0] ST_DEC  = 5'd9;
	localparam logic [ST_W-1:0] ST_CLMP = 5'd10;
	localparam logic [ST_W-1:0] ST_THR  = 5'd11;
	localparam logic [ST_W-1:0] ST_CAP  = 5'd12;
	localparam logic [ST_W-1:0] ST_ACC  = 5'd13;
	localparam logic [ST_W-1:0] ST_BXS  = 5'd14;
	localparam logic [ST_W-1:0] ST_BXW  = 5'd15;
	localparam logic [ST_W-1:0] ST_BYS  = 5'd16;
	localparam logic [ST_W-1:0] ST_BYW  = 5'd17;
	localparam logic [ST_W-1:0] ST_SX   = 5'd18;
	localparam logic [ST_W-1:0] ST_SY   = 5'd19;
	localparam logic [ST_W-1:0] ST_SYG  = 5'd20;
	localparam logic [ST_W-1:0] ST_DONE = 5'd21;

	logic [ST_W-1:0] state_q, state_n;
	logic [OP_W-1:0] op;
	logic            out_valid_q;

	// next state and datapath command
	always_comb begin
		state_n = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_n = ST_MXX;
				end
			end
			ST_MXX: begin
				op      = OP_MXX;
				state_n = ST_MYY;
			end
			ST_MYY: begin
				op      = OP_MYY;
				state_n = ST_SQS;
			end
			ST_SQS: begin
				op      = OP_SQS;
				state_n = ST_SQW;
			end
			ST_SQW: begin
				if (!stat.sq_busy) begin
					op      = OP_MAG;
					state_n = ST_BR;
				end
			end
			ST_BR: begin
				if (stat.s_neg && stat.pm_nz) begin
					op      = OP_MBM;
					state_n = ST_FDS;
				end else if (stat.s_pos) begin
					op      = OP_MRISE;
					state_n = ST_RADD;
				end else begin
					op      = OP_BCOPY;
					state_n = ST_DEC;
				end
			end
			ST_FDS: begin
				op      = OP_FDIV;
				state_n = ST_FDW;
			end
			ST_FDW: begin
				if (!stat.dv_busy) begin
					op      = OP_FGET;
					state_n = ST_DEC;
				end
			end
			ST_RADD: begin
				op      = OP_RADD;
				state_n = ST_DEC;
			end
			ST_DEC: begin
				op      = OP_DEC;
				state_n = ST_CLMP;
			end
			ST_CLMP: begin
				op      = OP_CLMP;
				state_n = ST_THR;
			end
			ST_THR: begin
				op      = OP_THR;
				state_n = ST_CAP;
			end
			ST_CAP: begin
				op      = OP_CAP;
				state_n = ST_ACC;
			end
			ST_ACC: begin
				op      = OP_ACC;
				state_n = ST_BXS;
			end
			ST_BXS: begin
				op      = OP_BXDIV;
				state_n = ST_BXW;
			end
			ST_BXW: begin
				if (!stat.dv_busy) begin
					op      = OP_BXGET;
					state_n = ST_BYS;
				end
			end
			ST_BYS: begin
				op      = OP_BYDIV;
				state_n = ST_BYW;
			end
			ST_BYW: begin
				if (!stat.dv_busy) begin
					op      = OP_BYGET;
					state_n = ST_SX;
				end
			end
			ST_SX: begin
				op      = OP_MSX;
				state_n = ST_SY;
			end
			ST_SY: begin
				op      = OP_SXGET;
				state_n = ST_SYG;
			end
			ST_SYG: begin
				op      = OP_SYGET;
				state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					op      = OP_COMMIT;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (op == OP_COMMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cmd.op    = op;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/analog_stick_boost_filter.sv
// ----------------------------------------------------------------------------
// analog_stick_boost_filter
// Stick magnitude boost filter: boosted direction and scaled axes per sample.
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready) takes one request with axis_x, axis_y in
//   Q14. out channel (out_valid/out_ready) returns boosted_x/y and
//   scaled_x/y for every request, in order.
//   cfg channel (cfg_valid/cfg_ready) writes decay (index 0) and gain
//   (index 1); cfg_ready is always high, other indexes are dropped.
//   Write configuration only while the block is idle.
// timing
//   one sample at a time: the next request is taken once the result is
//   loaded into the output register. The time per sample is set by the
//   bit-serial divider (up to three divisions per sample) and the square
//   root sharing one sequencer; a falling smoothed change with a nonzero
//   old magnitude takes the extra division.
// reset
//   clears the filter history and output valid, decay back to 328 and gain
//   to 2.0.
// stalls
//   a finished result sits in the output register; the next sample is
//   accepted and computed meanwhile and waits for the register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module analog_stick_boost_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [asbf_pkg::AXIS_W-1:0] axis_x,
	input  logic signed [asbf_pkg::AXIS_W-1:0] axis_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [asbf_pkg::BOUT_W-1:0] boosted_x,
	output logic signed [asbf_pkg::BOUT_W-1:0] boosted_y,
	output logic signed [asbf_pkg::SOUT_W-1:0] scaled_x,
	output logic signed [asbf_pkg::SOUT_W-1:0] scaled_y,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [asbf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asbf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import asbf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	asbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	asbf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.axis_x    (axis_x),
		.axis_y    (axis_y),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.boosted_x (boosted_x),
		.boosted_y (boosted_y),
		.scaled_x  (scaled_x),
		.scaled_y  (scaled_y)
	);

endmodule

`default_nettype wire

FILE: rtl/asbf_chk.sv
// ----------------------------------------------------------------------------
// asbf_chk
// Port-level checks for the analog stick boost filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module asbf_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [asbf_pkg::BOUT_W-1:0] boosted_x,
	input logic signed [asbf_pkg::BOUT_W-1:0] boosted_y,
	input logic signed [asbf_pkg::SOUT_W-1:0] scaled_x,
	input logic signed [asbf_pkg::SOUT_W-1:0] scaled_y,
	input logic                               cfg_valid,
	input logic                               cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(boosted_x) &&
		$stable(boosted_y) && $stable(scaled_x) && $stable(scaled_y))
		else $error("stalled result changed");

	// one request in flight: no second accept right after one
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a result never appears the cycle after an accept
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result too early");

	// configuration is always taken
	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind analog_stick_boost_filter asbf_chk u_asbf_chk (.*);

`default_nettype wire

FILE: test/tb_analog_stick_boost_filter.sv
// ----------------------------------------------------------------------------
// tb_analog_stick_boost_filter
// Self-checking bench for the stick boost filter: directed stick samples,
// then random sample streams under several decay and gain settings, with
// random idling on both channels and one long output hold-off. Every result
// is held to its typed value or a bench model of magnitude, boost, overshoot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_analog_stick_boost_filter;
	import asbf_pkg::*;

	// spare register indexes, writes to them are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int N_PHASES = 9;
	localparam int RAND_PER_PHASE = 48;

	typedef struct {
		logic signed [BOUT_W-1:0] bx;
		logic signed [BOUT_W-1:0] by;
		logic signed [SOUT_W-1:0] sx;
		logic signed [SOUT_W-1:0] sy;
	} stick_out_t;

	typedef struct {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		bit                       typed;
		stick_out_t               res;
	} sample_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [AXIS_W-1:0]    axis_x = '0;
	logic signed [AXIS_W-1:0]    axis_y = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic signed [BOUT_W-1:0]    boosted_x;
	logic signed [BOUT_W-1:0]    boosted_y;
	logic signed [SOUT_W-1:0]    scaled_x;
	logic signed [SOUT_W-1:0]    scaled_y;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	// filter model state and registers
	logic [DECAY_W-1:0] mdl_decay;
	logic [GAIN_W-1:0]  mdl_gain;
	logic [MAG_W-1:0]   mdl_prev_mag;
	longint             mdl_prev_chg;
	logic [BOOST_W-1:0] mdl_boost;
	logic [ACC_W-1:0]   mdl_acc;

	stick_out_t  pending_results[$];
	sample_row_t sample_rows[$];
	int          mismatches = 0;
	bit          hold_off_req = 1'b0;
	bit          sender_idle_off = 1'b0;
	bit          receiver_idle_off = 1'b0;
	logic signed [AXIS_W-1:0] last_x = '0;
	logic signed [AXIS_W-1:0] last_y = '0;

	analog_stick_boost_filter dut (.*);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic longint root_floor(longint v);
		longint r;
		longint t;
		r = 0;
		for (int i = 16; i >= 0; i--) begin
			t = r | (longint'(1) << i);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// advance the filter model by one sample
	function automatic stick_out_t boost_predict(logic signed [AXIS_W-1:0] ax,
	                                             logic signed [AXIS_W-1:0] ay);
		longint x, y, m, pm, d, s, b, g, upper, acc, a, thr;
		stick_out_t r;
		x = ax;
		y = ay;
		m = root_floor(x * x + y * y);
		pm = mdl_prev_mag;
		d = m - pm;
		s = d + mdl_prev_chg;
		b = mdl_boost;
		g = mdl_gain;
		acc = mdl_acc;
		// rise grows, fall scales by new over old magnitude
		if (s < 0 && pm > 0)
			b = (b * m) / pm;
		else if (s > 0)
			b += ((g + ONE_Q14) * s) / (2 * ONE_Q14);
		b -= mdl_decay;
		upper = (m * g) / ONE_Q14;
		if (b > upper)
			b = upper;
		else if (b < m)
			b = m;
		// overshoot cap to 1.0
		if (b > ONE_Q14 && mdl_decay != 0) begin
			a = g - ONE_Q14;
			thr = (a * a) / mdl_decay;
			if (acc > thr)
				b = ONE_Q14;
		end
		b = clip(b, 0, 1048575);
		acc = clip(acc + b - ONE_Q14, 0, 16777215);
		if (m == 0) begin
			r.bx = '0;
			r.by = '0;
		end else begin
			r.bx = clip((x * b) / m, -262144, 262143);
			r.by = clip((y * b) / m, -262144, 262143);
		end
		r.sx = clip((x * (m + ONE_Q14)) / (2 * ONE_Q14), -32768, 32767);
		r.sy = clip((y * (m + ONE_Q14)) / (2 * ONE_Q14), -32768, 32767);
		mdl_prev_mag = m;
		mdl_prev_chg = d;
		mdl_boost = b;
		mdl_acc = acc;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(15, 90);
	endfunction

	task automatic add_row(int x, int y, bit typed = 1'b0, int bx = 0, int by = 0,
	                       int sx = 0, int sy = 0);
		sample_row_t row;
		row.x = x;
		row.y = y;
		row.typed = typed;
		row.res.bx = bx;
		row.res.by = by;
		row.res.sx = sx;
		row.res.sy = sy;
		sample_rows.push_back(row);
	endtask

	// drive one request, predict at acceptance
	task automatic send_sample(sample_row_t row);
		stick_out_t r;
		int gap;
		gap = sender_idle_off ? 0 : gap_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		axis_x = row.x;
		axis_y = row.y;
		in_valid = 1'b1;
		do @(posedge clk); while (!(in_ready === 1'b1));
		r = boost_predict(row.x, row.y);
		pending_results.push_back(row.typed ? row.res : r);
		last_x = row.x;
		last_y = row.y;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!(cfg_ready === 1'b1));
		if (idx == REG_DECAY)
			mdl_decay = data[DECAY_W-1:0];
		else if (idx == REG_GAIN)
			mdl_gain = data[GAIN_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// random stick sample, mostly in range and often close to the last one
	function automatic sample_row_t random_sample();
		sample_row_t row;
		int mode;
		row.typed = 1'b0;
		mode = $urandom_range(0, 9);
		case (mode)
			6: begin
				row.x = last_x + $signed($urandom_range(0, 800)) - 400;
				row.y = last_y + $signed($urandom_range(0, 800)) - 400;
			end
			7: begin
				row.x = last_x;
				row.y = last_y;
			end
			8: begin
				row.x = $urandom;
				row.y = $urandom;
			end
			9: begin
				row.x = ($urandom_range(0, 1) ? 16384 : -16384) * $urandom_range(0, 1);
				row.y = $urandom_range(0, 2) == 0 ? 0 : -16384;
			end
			default: begin
				row.x = $signed($urandom_range(0, 32768)) - 16384;
				row.y = $signed($urandom_range(0, 32768)) - 16384;
			end
		endcase
		return row;
	endfunction

	// result checker with random stalls and one long hold-off
	initial begin
		int stall;
		bit held;
		stick_out_t want;
		stall = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (2500) @(negedge clk);
			end
			if (stall > 0) begin
				stall--;
				out_ready = 1'b0;
			end else if (!receiver_idle_off && $urandom_range(0, 3) == 0) begin
				stall = gap_len();
				out_ready = stall == 0;
			end else begin
				out_ready = 1'b1;
			end
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("results with no request outstanding", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (boosted_x !== want.bx) report_mismatch("boosted_x", boosted_x, want.bx);
					if (boosted_y !== want.by) report_mismatch("boosted_y", boosted_y, want.by);
					if (scaled_x !== want.sx) report_mismatch("scaled_x", scaled_x, want.sx);
					if (scaled_y !== want.sy) report_mismatch("scaled_y", scaled_y, want.sy);
				end
			end
		end
	end

	// stimulus
	initial begin
		int n;
		mdl_decay = DECAY_RST;
		mdl_gain = GAIN_RST;
		mdl_prev_mag = '0;
		mdl_prev_chg = 0;
		mdl_boost = '0;
		mdl_acc = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed samples: zero after reset, extremes, steady, falls
		add_row(0, 0, 1'b1, 0, 0, 0, 0);
		add_row(0, 0, 1'b1, 0, 0, 0, 0);
		add_row(16384, 0);
		add_row(16384, 0);
		add_row(16384, 0);
		add_row(0, 0);
		add_row(0, 0);
		add_row(0, 0);
		add_row(-16384, 0);
		add_row(0, 16384);
		add_row(0, -16384);
		add_row(11585, 11585);
		add_row(8000, -3000);
		add_row(32767, 32767);
		add_row(-32768, -32768);
		add_row(-32768, 32767);
		add_row(1, 0);
		add_row(-1, -1);
		add_row(-16384, -16384);
		add_row(4000, 4000);
		add_row(2000, 2000);
		add_row(16384, 16384);
		foreach (sample_rows[i])
			send_sample(sample_rows[i]);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			in_valid = 1'b0;
			wait (pending_results.size() == 0);
			repeat (5) @(negedge clk);
			case (ph)
				0: begin
					write_reg(REG_DECAY, 17'd1);
					write_reg(REG_GAIN, 17'd131071);
				end
				1: begin
					write_reg(REG_DECAY, 17'd16384);
					write_reg(REG_GAIN, 17'd16384);
				end
				2: begin
					write_reg(REG_DECAY, 17'd0);
					write_reg(REG_GAIN, 17'd65536);
				end
				3: begin
					write_reg(REG_DECAY, 17'h1FFFF);
					write_reg(REG_GAIN, 17'd16385);
				end
				4: begin
					write_reg(REG_DECAY, 17'd328);
					write_reg(REG_GAIN, 17'd1000);
				end
				5: begin
					write_reg(REG_DECAY, 17'd50);
					write_reg(REG_GAIN, 17'd16600);
					write_reg(REG_SPARE_A, 17'd7);
					write_reg(REG_SPARE_B, 17'h1FFFF);
				end
				6: begin
					write_reg(REG_DECAY, 17'd2);
					write_reg(REG_GAIN, 17'd0);
				end
				7: begin
					write_reg(REG_DECAY, 17'd5);
					write_reg(REG_GAIN, 17'd20000);
				end
				default: begin
					write_reg(REG_DECAY, 17'd328);
					write_reg(REG_GAIN, 17'd32768);
				end
			endcase
			sender_idle_off = ph % 3 == 1;
			receiver_idle_off = ph % 4 == 2;
			hold_off_req = hold_off_req | (ph == 3);
			n = RAND_PER_PHASE;
			for (int i = 0; i < n; i++)
				send_sample(random_sample());
		end
		in_valid = 1'b0;

		wait (pending_results.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
